// ----- rtl/sh3_irradiance_projection_unit_assert.svh -----
// assertion macros for the spherical-harmonic projection modules, used by the merge stage
`ifndef SH3_IRRADIANCE_PROJECTION_UNIT_ASSERT_SVH
`define SH3_IRRADIANCE_PROJECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define SH3P_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SH3P_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sh3p_pkg.sv -----
// shared constants, types and arithmetic helpers for the sh3 projection unit
`default_nettype none

package sh3p_pkg;

    localparam int NUM_COEFS  = 9;
    localparam int NUM_CHAN   = 3;
    localparam int ACC_BITS   = 48;
    localparam int OUT_BITS   = 48;
    localparam int COLOR_BITS = 16;
    localparam int DIR_BITS   = 16;
    localparam int WGT_BITS   = 16;
    localparam int IDX_BITS   = 4;
    localparam int W_BITS     = COLOR_BITS + WGT_BITS;
    localparam int SQ_BITS    = 2 * DIR_BITS;
    localparam int LOBE_BITS  = 15;
    localparam int WK_BITS    = W_BITS + LOBE_BITS + 1;
    localparam int SHIFT_P    = 16;
    localparam int P_BITS     = WK_BITS - SHIFT_P - 1;
    localparam int BASIS_BITS = 33;
    localparam int PROD_BITS  = 64;
    localparam int SHIFT_T    = 30;
    localparam int TERM_BITS  = PROD_BITS - SHIFT_T;
    localparam int WIDE_BITS  = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;

    // coefficient numbers, band order
    localparam logic [IDX_BITS-1:0] COEF_DC   = 4'd0;
    localparam logic [IDX_BITS-1:0] COEF_Y    = 4'd1;
    localparam logic [IDX_BITS-1:0] COEF_Z    = 4'd2;
    localparam logic [IDX_BITS-1:0] COEF_X    = 4'd3;
    localparam logic [IDX_BITS-1:0] COEF_YX   = 4'd4;
    localparam logic [IDX_BITS-1:0] COEF_YZ   = 4'd5;
    localparam logic [IDX_BITS-1:0] COEF_ZZ   = 4'd6;
    localparam logic [IDX_BITS-1:0] COEF_ZX   = 4'd7;
    localparam logic [IDX_BITS-1:0] COEF_XXYY = 4'd8;
    localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(NUM_COEFS - 1);

    // cosine-lobe constants, q0.16
    localparam logic [LOBE_BITS-1:0] LOBE_Q16 [NUM_COEFS] = '{
        15'd5215, 15'd10430, 15'd10430, 15'd10430, 15'd19557,
        15'd19557, 15'd1630, 15'd19557, 15'd4889
    };

    localparam logic [WK_BITS-1:0] ROUND_P = WK_BITS'(64'd1 << (SHIFT_P - 1));
    localparam logic signed [PROD_BITS-1:0] ROUND_T = PROD_BITS'(64'd1 << (SHIFT_T - 1));
    localparam logic signed [BASIS_BITS-1:0] BASIS_ONE = BASIS_BITS'(64'd1 << SHIFT_T);

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [WIDE_BITS-1:0] OUT_MAX_W =
        WIDE_BITS'({1'b0, {(OUT_BITS-1){1'b1}}});
    localparam logic signed [WIDE_BITS-1:0] OUT_MIN_W = -OUT_MAX_W - 1;

    // weighted colors and direction products of one texel
    typedef struct packed {
        logic [NUM_CHAN-1:0][W_BITS-1:0] w;
        logic signed [DIR_BITS-1:0]      x;
        logic signed [DIR_BITS-1:0]      y;
        logic signed [DIR_BITS-1:0]      z;
        logic signed [SQ_BITS-1:0]       xx;
        logic signed [SQ_BITS-1:0]       yy;
        logic signed [SQ_BITS-1:0]       zz;
        logic signed [SQ_BITS-1:0]       xy;
        logic signed [SQ_BITS-1:0]       yz;
        logic signed [SQ_BITS-1:0]       zx;
    } front_t;

    typedef struct packed {
        logic acc_en;
        logic clear;
    } lane_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_t;

    typedef logic [NUM_CHAN-1:0][ACC_BITS-1:0] lane_sums_t;
    typedef lane_sums_t [NUM_COEFS-1:0] all_sums_t;

    // q2.30 basis term for one coefficient
    function automatic logic signed [BASIS_BITS-1:0] basis_term(
        input logic [IDX_BITS-1:0] k,
        input front_t f
    );
        logic signed [BASIS_BITS-1:0] r;
        unique case (k)
            COEF_DC:   r = BASIS_ONE;
            COEF_Y:    r = BASIS_BITS'(f.y) <<< (DIR_BITS - 1);
            COEF_Z:    r = BASIS_BITS'(f.z) <<< (DIR_BITS - 1);
            COEF_X:    r = BASIS_BITS'(f.x) <<< (DIR_BITS - 1);
            COEF_YX:   r = BASIS_BITS'(f.xy);
            COEF_YZ:   r = BASIS_BITS'(f.yz);
            COEF_ZZ:   r = BASIS_BITS'(f.zz) + (BASIS_BITS'(f.zz) <<< 1) - BASIS_ONE;
            COEF_ZX:   r = BASIS_BITS'(f.zx);
            COEF_XXYY: r = BASIS_BITS'(f.xx) - BASIS_BITS'(f.yy);
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0]  s,
        input logic signed [TERM_BITS-1:0] t
    );
        logic signed [ACC_BITS:0] r;
        r = (ACC_BITS+1)'(s) + (ACC_BITS+1)'(t);
        if (r[ACC_BITS] != r[ACC_BITS-1]) begin
            return r[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end
        return r[ACC_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [WIDE_BITS-1:0] e;
        e = WIDE_BITS'(v);
        if (e > OUT_MAX_W) begin
            e = OUT_MAX_W;
        end else if (e < OUT_MIN_W) begin
            e = OUT_MIN_W;
        end
        return e[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sh3_irradiance_projection_unit.sv -----
// texels pass front, lobe/basis and product registers into the sums; a last one starts the output
// throughput: one texel per cycle; after a last texel input pauses until it has reached the
//   sums and all nine coefficient words have been taken
// the nine lanes run in lock step behind a shared front multiply: lobe scale, basis product, accumulate
// reset (aresetn low, synchronous) clears stage valid flags, all 27 sums and the output run
`default_nettype none

module sh3_irradiance_projection_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [sh3p_pkg::COLOR_BITS-1:0]       s_color_red,
    input  wire logic [sh3p_pkg::COLOR_BITS-1:0]       s_color_green,
    input  wire logic [sh3p_pkg::COLOR_BITS-1:0]       s_color_blue,
    input  wire logic signed [sh3p_pkg::DIR_BITS-1:0]  s_dir_x,
    input  wire logic signed [sh3p_pkg::DIR_BITS-1:0]  s_dir_y,
    input  wire logic signed [sh3p_pkg::DIR_BITS-1:0]  s_dir_z,
    input  wire logic [sh3p_pkg::WGT_BITS-1:0]         s_texel_weight,
    input  wire logic                                  s_last_texel,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [sh3p_pkg::IDX_BITS-1:0]              m_coef_index,
    output logic signed [sh3p_pkg::OUT_BITS-1:0]       m_sum_red,
    output logic signed [sh3p_pkg::OUT_BITS-1:0]       m_sum_green,
    output logic signed [sh3p_pkg::OUT_BITS-1:0]       m_sum_blue,
    output logic                                       m_last_coef
);
    import sh3p_pkg::*;

    stage_t    f_reg, f_next;
    stage_t    a_reg, a_next;
    stage_t    b_reg, b_next;
    logic      accept;
    logic      last_in_flight;
    front_t    front;
    lane_ctl_t ctl;
    all_sums_t sums;

    // hold off while a last word is in the pipe or the previous run is still going out
    assign last_in_flight = (f_reg.valid && f_reg.last) || (a_reg.valid && a_reg.last)
                          || (b_reg.valid && b_reg.last);
    assign s_ready = !m_valid && !last_in_flight;
    assign accept  = s_valid && s_ready;

    always_comb begin
        f_next.valid = accept;
        f_next.last  = accept && s_last_texel;
        a_next       = f_reg;
        b_next       = a_reg;
        ctl.acc_en   = b_reg.valid;
        ctl.clear    = b_reg.valid && b_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
        end else begin
            f_reg <= f_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    sh3p_front u_front (
        .aclk         (aclk),
        .load         (accept),
        .color_red    (s_color_red),
        .color_green  (s_color_green),
        .color_blue   (s_color_blue),
        .dir_x        (s_dir_x),
        .dir_y        (s_dir_y),
        .dir_z        (s_dir_z),
        .texel_weight (s_texel_weight),
        .front        (front)
    );

    for (genvar k = 0; k < NUM_COEFS; k++) begin : g_lane
        sh3p_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .coef    (IDX_BITS'(k)),
            .front   (front),
            .ctl     (ctl),
            .sums    (sums[k])
        );
    end

    sh3p_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (ctl.clear),
        .sums         (sums),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_coef_index (m_coef_index),
        .m_sum_red    (m_sum_red),
        .m_sum_green  (m_sum_green),
        .m_sum_blue   (m_sum_blue),
        .m_last_coef  (m_last_coef)
    );

endmodule

`default_nettype wire

// ----- rtl/sh3p_front.sv -----
// front stage: solid-angle weighting and direction products of one texel
`default_nettype none

module sh3p_front (
    input  wire logic                                  aclk,
    input  wire logic                                  load,
    input  wire logic [sh3p_pkg::COLOR_BITS-1:0]       color_red,
    input  wire logic [sh3p_pkg::COLOR_BITS-1:0]       color_green,
    input  wire logic [sh3p_pkg::COLOR_BITS-1:0]       color_blue,
    input  wire logic signed [sh3p_pkg::DIR_BITS-1:0]  dir_x,
    input  wire logic signed [sh3p_pkg::DIR_BITS-1:0]  dir_y,
    input  wire logic signed [sh3p_pkg::DIR_BITS-1:0]  dir_z,
    input  wire logic [sh3p_pkg::WGT_BITS-1:0]         texel_weight,
    output sh3p_pkg::front_t                           front
);
    import sh3p_pkg::*;

    front_t front_reg;
    front_t front_next;

    always_comb begin
        front_next.w[0] = W_BITS'(color_red) * W_BITS'(texel_weight);
        front_next.w[1] = W_BITS'(color_green) * W_BITS'(texel_weight);
        front_next.w[2] = W_BITS'(color_blue) * W_BITS'(texel_weight);
        front_next.x    = dir_x;
        front_next.y    = dir_y;
        front_next.z    = dir_z;
        front_next.xx   = SQ_BITS'(dir_x) * SQ_BITS'(dir_x);
        front_next.yy   = SQ_BITS'(dir_y) * SQ_BITS'(dir_y);
        front_next.zz   = SQ_BITS'(dir_z) * SQ_BITS'(dir_z);
        front_next.xy   = SQ_BITS'(dir_y) * SQ_BITS'(dir_x);
        front_next.yz   = SQ_BITS'(dir_y) * SQ_BITS'(dir_z);
        front_next.zx   = SQ_BITS'(dir_z) * SQ_BITS'(dir_x);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

// ----- rtl/sh3p_lane.sv -----
// one coefficient lane: lobe scaling, basis product and saturating rgb sums
`default_nettype none

module sh3p_lane (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [sh3p_pkg::IDX_BITS-1:0] coef,
    input  wire sh3p_pkg::front_t              front,
    input  wire sh3p_pkg::lane_ctl_t           ctl,
    output sh3p_pkg::lane_sums_t               sums
);
    import sh3p_pkg::*;

    logic [WK_BITS-1:0]                wk      [NUM_CHAN];
    logic [P_BITS-1:0]                 p_reg   [NUM_CHAN];
    logic [P_BITS-1:0]                 p_next  [NUM_CHAN];
    logic signed [BASIS_BITS-1:0]      basis_reg;
    logic signed [BASIS_BITS-1:0]      basis_next;
    logic signed [PROD_BITS-1:0]       prod_reg  [NUM_CHAN];
    logic signed [PROD_BITS-1:0]       prod_next [NUM_CHAN];
    logic signed [PROD_BITS-1:0]       rs      [NUM_CHAN];
    logic signed [TERM_BITS-1:0]       term    [NUM_CHAN];
    logic signed [ACC_BITS-1:0]        sum_now [NUM_CHAN];
    logic signed [ACC_BITS-1:0]        sum_reg [NUM_CHAN];
    logic signed [ACC_BITS-1:0]        sum_next[NUM_CHAN];

    always_comb begin
        basis_next = basis_term(coef, front);
        for (int c = 0; c < NUM_CHAN; c++) begin
            // weighted color times lobe constant, rounded half up
            wk[c]        = WK_BITS'(front.w[c]) * WK_BITS'(LOBE_Q16[coef]) + ROUND_P;
            p_next[c]    = wk[c][SHIFT_P +: P_BITS];
            prod_next[c] = PROD_BITS'($signed({1'b0, p_reg[c]})) * PROD_BITS'(basis_reg);
            rs[c]        = prod_reg[c] + ROUND_T;
            term[c]      = rs[c][PROD_BITS-1:SHIFT_T];
            sum_now[c]   = ctl.acc_en ? sat_add(sum_reg[c], term[c]) : sum_reg[c];
            sum_next[c]  = ctl.clear ? '0 : sum_now[c];
            sums[c]      = sum_now[c];
        end
    end

    always_ff @(posedge aclk) begin
        basis_reg <= basis_next;
        for (int c = 0; c < NUM_CHAN; c++) begin
            p_reg[c]    <= p_next[c];
            prod_reg[c] <= prod_next[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                sum_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sh3p_emit.sv -----
// merge stage: snapshots all lane sums on the last texel and shifts them out
`default_nettype none

`include "sh3_irradiance_projection_unit_assert.svh"

module sh3p_emit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  load,
    input  wire sh3p_pkg::all_sums_t                   sums,
    input  wire logic                                  m_ready,
    output logic                                       m_valid,
    output logic [sh3p_pkg::IDX_BITS-1:0]              m_coef_index,
    output logic signed [sh3p_pkg::OUT_BITS-1:0]       m_sum_red,
    output logic signed [sh3p_pkg::OUT_BITS-1:0]       m_sum_green,
    output logic signed [sh3p_pkg::OUT_BITS-1:0]       m_sum_blue,
    output logic                                       m_last_coef
);
    import sh3p_pkg::*;

    logic [NUM_CHAN-1:0][OUT_BITS-1:0] snap_reg  [NUM_COEFS];
    logic [NUM_CHAN-1:0][OUT_BITS-1:0] snap_next [NUM_COEFS];
    logic [IDX_BITS-1:0]               idx_reg;
    logic [IDX_BITS-1:0]               idx_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              pop;

    assign pop = busy_reg && m_ready;

    always_comb begin
        snap_next = snap_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        priority if (load) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    snap_next[k][c] = clamp_out(sums[k][c]);
                end
            end
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (pop) begin
            // word 0 leaves, the rest move up one place
            for (int k = 0; k < NUM_COEFS - 1; k++) begin
                snap_next[k] = snap_reg[k+1];
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LAST_IDX) begin
                busy_next = 1'b0;
            end
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    assign m_valid      = busy_reg;
    assign m_coef_index = idx_reg;
    assign m_sum_red    = snap_reg[0][0];
    assign m_sum_green  = snap_reg[0][1];
    assign m_sum_blue   = snap_reg[0][2];
    assign m_last_coef  = (idx_reg == LAST_IDX);

    `SH3P_ASSERT_IMP(a_load_when_idle, aclk, aresetn, load, !busy_reg, "snapshot overwritten")
    `SH3P_ASSERT_NEXT(a_load_starts_run, aclk, aresetn, load, busy_reg && idx_reg == '0, "run start")
    `SH3P_ASSERT_NEXT(a_run_ends, aclk, aresetn, pop && idx_reg == LAST_IDX, !busy_reg, "run end")
    `SH3P_ASSERT_IMP(a_idx_range, aclk, aresetn, busy_reg, idx_reg <= LAST_IDX, "index range")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the sh3 irradiance projection unit
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sh3p_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int SAT_TEXELS    = 8;
    localparam int PHASE_TEXELS  = 24;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [COLOR_BITS-1:0]      red;
        logic [COLOR_BITS-1:0]      green;
        logic [COLOR_BITS-1:0]      blue;
        logic signed [DIR_BITS-1:0] x;
        logic signed [DIR_BITS-1:0] y;
        logic signed [DIR_BITS-1:0] z;
        logic [WGT_BITS-1:0]        weight;
        logic                       last;
    } texel_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] index;
        logic [OUT_BITS-1:0] red;
        logic [OUT_BITS-1:0] green;
        logic [OUT_BITS-1:0] blue;
        logic                last;
    } coef_word_t;

    // projection model: 27 running sums and the coefficient words still owed by the block
    class sh_coef_board;
        longint     running_sums[NUM_COEFS*NUM_CHAN];
        coef_word_t pending_coefs[$];
        int         errors;
        int         words_checked;
        int         sat_hits;
        int         texels;
        int         runs;

        function longint lobe_q16(logic [IDX_BITS-1:0] k);
            case (k)
                COEF_DC:                        return 5215;
                COEF_Y, COEF_Z, COEF_X:         return 10430;
                COEF_YX, COEF_YZ, COEF_ZX:      return 19557;
                COEF_ZZ:                        return 1630;
                COEF_XXYY:                      return 4889;
                default:                        return 0;
            endcase
        endfunction

        // q2.30 basis value of one coefficient
        function longint basis_q30(logic [IDX_BITS-1:0] k, longint x, longint y, longint z);
            case (k)
                COEF_DC:   return longint'(1) <<< 30;
                COEF_Y:    return y * 32768;
                COEF_Z:    return z * 32768;
                COEF_X:    return x * 32768;
                COEF_YX:   return y * x;
                COEF_YZ:   return y * z;
                COEF_ZZ:   return 3 * z * z - (longint'(1) <<< 30);
                COEF_ZX:   return z * x;
                COEF_XXYY: return x * x - y * y;
                default:   return 0;
            endcase
        endfunction

        function longint add_clipped(longint s, longint t);
            longint hi;
            longint lo;
            longint r;
            hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
            lo = -hi - 1;
            r = s + t;
            if (r > hi || r < lo) sat_hits++;
            if (r > hi) return hi;
            if (r < lo) return lo;
            return r;
        endfunction

        function logic [OUT_BITS-1:0] to_out(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return OUT_BITS'(v);
        endfunction

        function void project_texel(texel_t t);
            longint     x;
            longint     y;
            longint     z;
            longint     wt;
            longint     b;
            longint     p;
            longint     term;
            longint     w[NUM_CHAN];
            coef_word_t cw;
            x = longint'($signed(t.x));
            y = longint'($signed(t.y));
            z = longint'($signed(t.z));
            wt = longint'(t.weight);
            w[0] = longint'(t.red) * wt;
            w[1] = longint'(t.green) * wt;
            w[2] = longint'(t.blue) * wt;
            for (int k = 0; k < NUM_COEFS; k++) begin
                b = basis_q30(IDX_BITS'(k), x, y, z);
                for (int c = 0; c < NUM_CHAN; c++) begin
                    p = (w[c] * lobe_q16(IDX_BITS'(k)) + 32768) >>> 16;
                    // arithmetic shift gives the floor, so this rounds half up
                    term = (p * b + (longint'(1) <<< 29)) >>> 30;
                    running_sums[k*NUM_CHAN+c] = add_clipped(running_sums[k*NUM_CHAN+c], term);
                end
            end
            texels++;
            if (t.last) begin
                runs++;
                for (int k = 0; k < NUM_COEFS; k++) begin
                    cw.index = IDX_BITS'(k);
                    cw.red   = to_out(running_sums[k*NUM_CHAN]);
                    cw.green = to_out(running_sums[k*NUM_CHAN+1]);
                    cw.blue  = to_out(running_sums[k*NUM_CHAN+2]);
                    cw.last  = (k == NUM_COEFS - 1);
                    pending_coefs.push_back(cw);
                end
                foreach (running_sums[i]) running_sums[i] = 0;
            end
        endfunction

        function void compare(string field, logic [IDX_BITS-1:0] idx,
                              logic [OUT_BITS-1:0] want, logic [OUT_BITS-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: coef %0d %s mismatch, expected %0h, got %0h",
                         $time, idx, field, want, got);
            end
        endfunction

        function void check_coef_word(coef_word_t got);
            coef_word_t want;
            if (pending_coefs.size() == 0) begin
                errors++;
                $display("%0t: coefficient word with nothing expected, expected none, got index %0d",
                         $time, got.index);
                return;
            end
            want = pending_coefs.pop_front();
            words_checked++;
            compare("index", want.index, OUT_BITS'(want.index), OUT_BITS'(got.index));
            compare("red", want.index, want.red, got.red);
            compare("green", want.index, want.green, got.green);
            compare("blue", want.index, want.blue, got.blue);
            compare("last", want.index, OUT_BITS'(want.last), OUT_BITS'(got.last));
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [COLOR_BITS-1:0]       s_color_red = '0;
    logic [COLOR_BITS-1:0]       s_color_green = '0;
    logic [COLOR_BITS-1:0]       s_color_blue = '0;
    logic signed [DIR_BITS-1:0]  s_dir_x = '0;
    logic signed [DIR_BITS-1:0]  s_dir_y = '0;
    logic signed [DIR_BITS-1:0]  s_dir_z = '0;
    logic [WGT_BITS-1:0]         s_texel_weight = '0;
    logic                        s_last_texel = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [IDX_BITS-1:0]         m_coef_index;
    logic signed [OUT_BITS-1:0]  m_sum_red;
    logic signed [OUT_BITS-1:0]  m_sum_green;
    logic signed [OUT_BITS-1:0]  m_sum_blue;
    logic                        m_last_coef;

    sh_coef_board board = new;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    sh3_irradiance_projection_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_color_red    (s_color_red),
        .s_color_green  (s_color_green),
        .s_color_blue   (s_color_blue),
        .s_dir_x        (s_dir_x),
        .s_dir_y        (s_dir_y),
        .s_dir_z        (s_dir_z),
        .s_texel_weight (s_texel_weight),
        .s_last_texel   (s_last_texel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_coef_index   (m_coef_index),
        .m_sum_red      (m_sum_red),
        .m_sum_green    (m_sum_green),
        .m_sum_blue     (m_sum_blue),
        .m_last_coef    (m_last_coef)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("run stopped after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_coef_word({m_coef_index, m_sum_red, m_sum_green, m_sum_blue,
                                   m_last_coef});
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_texel(input texel_t t);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_color_red    <= t.red;
        s_color_green  <= t.green;
        s_color_blue   <= t.blue;
        s_dir_x        <= t.x;
        s_dir_y        <= t.y;
        s_dir_z        <= t.z;
        s_texel_weight <= t.weight;
        s_last_texel   <= t.last;
        do @(posedge aclk); while (!s_ready);
        board.project_texel(t);
    endtask

    task automatic send_fields(input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z,
                               input logic [15:0] wt, input logic last);
        texel_t t;
        t = '{red: r, green: g, blue: b, x: x, y: y, z: z, weight: wt, last: last};
        send_texel(t);
    endtask

    // runs of 1 to 8 texels, each closed by a last word
    task automatic random_runs(input int count);
        texel_t t;
        int     len;
        int     sent;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                t.red    = pick16();
                t.green  = pick16();
                t.blue   = pick16();
                t.x      = pick16();
                t.y      = pick16();
                t.z      = pick16();
                t.weight = pick16();
                t.last   = (i == len - 1);
                send_texel(t);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty sums, full-scale colors and axes, zero weight, tiny rounding
        send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
        send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0);
        send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0);
        send_fields(16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1);
        send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1234, 16'hC000, 16'h4000, 16'h0000, 1);
        send_fields(16'h0100, 16'h0100, 16'h0100, 16'h7FFF, 16'h0000, 16'h0000, 16'h0001, 0);
        send_fields(16'h0100, 16'h0200, 16'h0080, 16'h0000, 16'h7FFF, 16'h0000, 16'h0400, 0);
        send_fields(16'h0100, 16'h0200, 16'h0080, 16'h0000, 16'h0000, 16'h7FFF, 16'h0400, 1);
        send_fields(16'h0001, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1);
        send_fields(16'h0001, 16'h0003, 16'h0007, 16'h0001, 16'hFFFF, 16'h0001, 16'h8000, 1);
        send_fields(16'h8000, 16'h7FFF, 16'h5555, 16'h5A82, 16'h5A82, 16'h0000, 16'h7FFF, 0);
        send_fields(16'hAAAA, 16'h5555, 16'h00FF, 16'h0000, 16'h5A82, 16'hA57E, 16'h1000, 0);
        send_fields(16'h1234, 16'hFEDC, 16'h0F0F, 16'h49E7, 16'hB619, 16'h49E7, 16'h2000, 1);
        send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            random_runs(PHASE_TEXELS);
        end

        // output held off while texels keep coming, so the unit backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = LONG_HOLD;
        random_runs(20);

        // short run of full-scale texels along the negative diagonal: the largest
        // per-texel terms, cross terms positive and linear terms negative
        for (int i = 0; i < SAT_TEXELS; i++) begin
            send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF,
                        i == SAT_TEXELS - 1);
        end
        send_fields(16'h0100, 16'h0100, 16'h0100, 16'h4000, 16'hC000, 16'h2000, 16'h0800, 1);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending_coefs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d texels in %0d runs, %0d coefficient words checked",
                 board.texels, board.runs, board.words_checked);
        $display("with idle and stall mixes, a %0d-cycle output hold, %0d clipped sum updates",
                 LONG_HOLD, board.sat_hits);
        if (board.errors == 0 && board.pending_coefs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/sh3p_pkg.sv
rtl/sh3p_front.sv
rtl/sh3p_lane.sv
rtl/sh3p_emit.sv
rtl/sh3_irradiance_projection_unit.sv
test/testbench.sv
